### rtl/vrt_pkg.sv
// Package for the voxel ray traversal block: sequencer states, axis sign codes
// and fixed widths shared by the top level. No dependencies.
package vrt_pkg;

    localparam int T_BITS_DEF = 48;
    localparam int DIV_W      = 48;
    localparam int CNT_W      = 6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_STORE
    } vrt_state_t;

    typedef enum logic [1:0] {
        OP_CELL,
        OP_BOUND,
        OP_SPACE
    } vrt_op_t;

    localparam logic [1:0] SIGN_NONE = 2'd0;
    localparam logic [1:0] SIGN_POS  = 2'd1;
    localparam logic [1:0] SIGN_NEG  = 2'd3;

    localparam logic [1:0] REG_CELL_X = 2'd0;
    localparam logic [1:0] REG_CELL_Y = 2'd1;
    localparam logic [1:0] REG_CELL_Z = 2'd2;

endpackage

### rtl/voxel_ray_traversal_dda.sv
// Voxel ray traversal top level: APB cell size registers, start sequencer with a
// shared bit-serial divider, and the advance step. Depends on vrt_pkg.
// An advance item is accepted and its result appears the next cycle.
// A start item runs up to nine divisions on one shared 48-step divider, each with a
// load and a store state (one division for an axis whose heading is zero, three for
// any other axis); no item is taken until the sequencer is back in idle.
// A new item is accepted when the sequencer is idle and the output register is free.
// Reset (aresetn low, synchronous) sets cell sizes to 1.0 and clears the ray state.
module voxel_ray_traversal_dda
    import vrt_pkg::*;
#(
    parameter int T_BITS = T_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // origin_x, origin_y, origin_z, heading_x, heading_y, heading_z
    input  logic [143:0] s_tdata,
    // req_type
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // cell_x, cell_y, cell_z, t_now
    output logic [143:0] m_tdata,
    // no_heading
    output logic [0:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic [T_BITS-1:0] TMAX = '1;

    vrt_state_t        state_reg, state_next;
    logic [31:0]       size_reg [3];
    logic [1:0]        sign_reg [3];
    logic [T_BITS-1:0] space_reg [3];
    logic [T_BITS-1:0] bound_reg [3];
    logic [31:0]       cell_reg [3];
    logic [T_BITS-1:0] tcur_reg;
    logic              hzero_reg;
    logic [31:0]       org_reg [3];
    logic [15:0]       hdg_reg [3];
    logic [1:0]        axis_reg;
    vrt_op_t           op_reg;
    logic [31:0]       rem_hold_reg;
    logic [DIV_W-1:0]  dvd_reg;
    logic [31:0]       dsr_reg;
    logic [31:0]       drem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              m_tvalid_reg;
    logic [143:0]      m_tdata_reg;
    logic              m_tuser_reg;

    logic              s_acc, wr_acc, adv_acc, start_acc, div_last;
    logic [31:0]       size_eff, span;
    logic              hneg, hzero_ax;
    logic [16:0]       mag;
    logic [32:0]       rem_sh;
    logic              rem_ge;
    logic [1:0]        pick;
    logic [T_BITS:0]   bsum;
    logic [T_BITS-1:0] bound_adv, q_sat;
    logic [31:0]       cell_adv;
    logic              all_zero;

    assign pready   = 1'b1;
    assign s_acc    = s_tvalid && s_tready;
    assign adv_acc  = s_acc && s_tuser[0];
    assign start_acc = s_acc && !s_tuser[0];
    assign wr_acc   = psel && penable && pwrite && pready;
    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign div_last = (cnt_reg == CNT_W'(DIV_W - 1));

    always_comb begin
        case (paddr[3:2])
            REG_CELL_X: prdata = size_reg[0];
            REG_CELL_Y: prdata = size_reg[1];
            REG_CELL_Z: prdata = size_reg[2];
            default:    prdata = 32'd0;
        endcase
    end

    // Per-axis operands for the current division.
    always_comb begin
        size_eff = (size_reg[axis_reg] == 32'd0) ? 32'd1 : size_reg[axis_reg];
        hneg     = hdg_reg[axis_reg][15];
        hzero_ax = (hdg_reg[axis_reg] == 16'd0);
        mag      = hneg ? (17'h10000 - {1'b0, hdg_reg[axis_reg]}) : {1'b0, hdg_reg[axis_reg]};
        span     = hneg ? rem_hold_reg : (size_eff - rem_hold_reg);
        rem_sh   = {drem_reg, dvd_reg[DIV_W-1]};
        rem_ge   = (rem_sh >= {1'b0, dsr_reg});
        q_sat    = (64'(dvd_reg) > 64'(TMAX)) ? TMAX : T_BITS'(dvd_reg);
        all_zero = (hdg_reg[0] == 16'd0) && (hdg_reg[1] == 16'd0) && (hdg_reg[2] == 16'd0);
    end

    // Advance: nearest boundary; on a tie the later axis wins.
    always_comb begin
        if (bound_reg[0] < bound_reg[1]) begin
            pick = (bound_reg[0] < bound_reg[2]) ? 2'd0 : 2'd2;
        end else begin
            pick = (bound_reg[1] < bound_reg[2]) ? 2'd1 : 2'd2;
        end
        bsum      = {1'b0, bound_reg[pick]} + {1'b0, space_reg[pick]};
        bound_adv = bsum[T_BITS] ? TMAX : bsum[T_BITS-1:0];
        case (sign_reg[pick])
            SIGN_POS: cell_adv = cell_reg[pick] + 32'd1;
            SIGN_NEG: cell_adv = cell_reg[pick] - 32'd1;
            default:  cell_adv = cell_reg[pick];
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (start_acc) state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_DIV;
            ST_DIV:   if (div_last) state_next = ST_STORE;
            ST_STORE: begin
                if ((op_reg == OP_SPACE || (op_reg == OP_CELL && hzero_ax))
                        && axis_reg == 2'd2) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_LOAD;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < 3; a++) begin
                size_reg[a]  <= 32'd65536;
                sign_reg[a]  <= SIGN_NONE;
                space_reg[a] <= TMAX;
                bound_reg[a] <= TMAX;
                cell_reg[a]  <= 32'd0;
            end
            tcur_reg     <= '0;
            hzero_reg    <= 1'b1;
            m_tvalid_reg <= 1'b0;
            axis_reg     <= 2'd0;
            op_reg       <= OP_CELL;
            cnt_reg      <= '0;
        end else begin
            if (wr_acc && paddr[3:2] != 2'd3) begin
                size_reg[paddr[3:2]] <= pwdata;
            end
            if (m_tvalid_reg && m_tready && !adv_acc) begin
                m_tvalid_reg <= 1'b0;
            end
            if (start_acc) begin
                for (int a = 0; a < 3; a++) begin
                    org_reg[a] <= s_tdata[32*a +: 32];
                    hdg_reg[a] <= s_tdata[96 + 16*a +: 16];
                end
                axis_reg <= 2'd0;
                op_reg   <= OP_CELL;
            end
            if (adv_acc) begin
                if (!hzero_reg) begin
                    tcur_reg        <= bound_reg[pick];
                    cell_reg[pick]  <= cell_adv;
                    bound_reg[pick] <= bound_adv;
                end
                m_tvalid_reg <= 1'b1;
                for (int a = 0; a < 3; a++) begin
                    m_tdata_reg[32*a +: 32] <= (!hzero_reg && pick == 2'(a)) ?
                                               cell_adv : cell_reg[a];
                end
                m_tdata_reg[143:96] <= hzero_reg ? 48'(tcur_reg) : 48'(bound_reg[pick]);
                m_tuser_reg         <= hzero_reg;
            end
            case (state_reg)
                ST_LOAD: begin
                    cnt_reg  <= '0;
                    drem_reg <= 32'd0;
                    case (op_reg)
                        OP_CELL: begin
                            dvd_reg <= DIV_W'(org_reg[axis_reg]);
                            dsr_reg <= size_eff;
                        end
                        OP_BOUND: begin
                            dvd_reg <= DIV_W'({span, 15'd0});
                            dsr_reg <= 32'(mag);
                        end
                        default: begin
                            dvd_reg <= DIV_W'({size_eff, 15'd0});
                            dsr_reg <= 32'(mag);
                        end
                    endcase
                end
                ST_DIV: begin
                    cnt_reg  <= cnt_reg + CNT_W'(1);
                    drem_reg <= rem_ge ? 32'(rem_sh - {1'b0, dsr_reg}) : rem_sh[31:0];
                    dvd_reg  <= {dvd_reg[DIV_W-2:0], rem_ge};
                end
                ST_STORE: begin
                    case (op_reg)
                        OP_CELL: begin
                            cell_reg[axis_reg] <= dvd_reg[31:0];
                            rem_hold_reg       <= drem_reg;
                            if (hzero_ax) begin
                                sign_reg[axis_reg]  <= SIGN_NONE;
                                bound_reg[axis_reg] <= TMAX;
                                space_reg[axis_reg] <= TMAX;
                                axis_reg            <= axis_reg + 2'd1;
                            end else begin
                                sign_reg[axis_reg] <= hneg ? SIGN_NEG : SIGN_POS;
                                op_reg             <= OP_BOUND;
                            end
                        end
                        OP_BOUND: begin
                            bound_reg[axis_reg] <= q_sat;
                            op_reg              <= OP_SPACE;
                        end
                        default: begin
                            space_reg[axis_reg] <= q_sat;
                            op_reg              <= OP_CELL;
                            axis_reg            <= axis_reg + 2'd1;
                        end
                    endcase
                    if (state_next == ST_IDLE) begin
                        tcur_reg     <= '0;
                        hzero_reg    <= all_zero;
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg[31:0]  <= cell_reg[0];
                        m_tdata_reg[63:32] <= cell_reg[1];
                        m_tdata_reg[95:64] <= (op_reg == OP_CELL) ? dvd_reg[31:0] : cell_reg[2];
                        m_tdata_reg[143:96] <= 48'd0;
                        m_tuser_reg         <= all_zero;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == ST_IDLE)
        else $error("Input taken while the sequencer is busy.");

    a_adv_result: assert property (@(posedge aclk) disable iff (!aresetn)
        adv_acc |=> m_tvalid_reg)
        else $error("Advance item gave no result.");

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start_acc |=> !m_tvalid_reg && state_reg == ST_LOAD)
        else $error("Start item did not enter the division sequence.");

    a_hold_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        adv_acc && hzero_reg |=> $stable(tcur_reg) && $stable(cell_reg[0]))
        else $error("Advance changed state with no heading.");

endmodule

### test/voxel_ray_traversal_dda_check.sv
// Checker for the voxel ray traversal block: watches both item channels, predicts
// each result from its own copy of the ray state and compares. Depends on vrt_pkg.
`timescale 1ns / 1ps

module voxel_ray_traversal_dda_check
    import vrt_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [143:0] s_tdata,
    input  logic [0:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [143:0] m_tdata,
    input  logic [0:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output int           fail_count,
    output int           pending
);

    localparam logic [47:0] T_TOP = {48{1'b1}};

    typedef struct packed {
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic [47:0] t;
        logic        nh;
    } voxel_hit_t;

    logic [31:0] cell_len [3];
    logic [1:0]  step_dir [3];
    logic [47:0] t_gap [3];
    logic [47:0] t_next [3];
    logic [31:0] voxel [3];
    logic [47:0] t_at;
    logic        still;
    voxel_hit_t  hit_queue [$];

    function automatic logic [47:0] clamp_t(logic [63:0] v);
        return (v > {16'd0, T_TOP}) ? T_TOP : v[47:0];
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: %s got %h want %h", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic walk_item(logic req, logic [143:0] d);
        logic [63:0] org, size, rem, mag, span;
        logic [15:0] h;
        bit          all_zero;
        int          pick;
        voxel_hit_t  r;
        if (!req) begin
            all_zero = 1'b1;
            for (int a = 0; a < 3; a++) begin
                org = {32'd0, d[32*a +: 32]};
                h = d[96 + 16*a +: 16];
                size = (cell_len[a] == 32'd0) ? 64'd1 : {32'd0, cell_len[a]};
                rem = org % size;
                voxel[a] = 32'(org / size);
                if (h == 16'd0) begin
                    step_dir[a] = SIGN_NONE;
                    t_next[a] = T_TOP;
                    t_gap[a] = T_TOP;
                end else begin
                    all_zero = 1'b0;
                    mag = h[15] ? (64'h10000 - {48'd0, h}) : {48'd0, h};
                    step_dir[a] = h[15] ? SIGN_NEG : SIGN_POS;
                    span = h[15] ? rem : size - rem;
                    t_next[a] = clamp_t((span << 15) / mag);
                    t_gap[a] = clamp_t((size << 15) / mag);
                end
            end
            still = all_zero;
            t_at = '0;
        end else if (!still) begin
            if (t_next[0] < t_next[1]) pick = (t_next[0] < t_next[2]) ? 0 : 2;
            else pick = (t_next[1] < t_next[2]) ? 1 : 2;
            t_at = t_next[pick];
            if (step_dir[pick] == SIGN_POS) voxel[pick] = voxel[pick] + 32'd1;
            else if (step_dir[pick] == SIGN_NEG) voxel[pick] = voxel[pick] - 32'd1;
            t_next[pick] = clamp_t({16'd0, t_next[pick]} + {16'd0, t_gap[pick]});
        end
        r = '{voxel[0], voxel[1], voxel[2], t_at, still};
        hit_queue.push_back(r);
    endtask

    always @(posedge aclk) begin
        voxel_hit_t w;
        if (!aresetn) begin
            for (int a = 0; a < 3; a++) begin
                cell_len[a] = 32'h10000;
                step_dir[a] = SIGN_NONE;
                t_gap[a] = T_TOP;
                t_next[a] = T_TOP;
                voxel[a] = '0;
            end
            t_at = '0;
            still = 1'b1;
            hit_queue.delete();
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr[3:2] == REG_CELL_X) cell_len[0] = pwdata;
                else if (paddr[3:2] == REG_CELL_Y) cell_len[1] = pwdata;
                else if (paddr[3:2] == REG_CELL_Z) cell_len[2] = pwdata;
            end
            if (m_tvalid && m_tready) begin
                if (hit_queue.size() == 0) begin
                    report("unexpected item", m_tdata[63:0], 64'd0);
                end else begin
                    w = hit_queue.pop_front();
                    if (m_tdata[31:0] != w.cx)
                        report("cell_x", 64'(m_tdata[31:0]), 64'(w.cx));
                    if (m_tdata[63:32] != w.cy)
                        report("cell_y", 64'(m_tdata[63:32]), 64'(w.cy));
                    if (m_tdata[95:64] != w.cz)
                        report("cell_z", 64'(m_tdata[95:64]), 64'(w.cz));
                    if (m_tdata[143:96] != w.t)
                        report("t_now", 64'(m_tdata[143:96]), 64'(w.t));
                    if (m_tuser[0] != w.nh)
                        report("no_heading", 64'(m_tuser[0]), 64'(w.nh));
                end
            end
            if (s_tvalid && s_tready) walk_item(s_tuser[0], s_tdata);
        end
        pending = hit_queue.size();
    end

    initial fail_count = 0;

endmodule

### test/voxel_ray_traversal_dda_test.sv
// Testbench top for the voxel ray traversal block: drives rays and advances with
// random gaps and stalls, sets cell sizes over APB. Depends on vrt_pkg, the top level and the checker.
`timescale 1ns / 1ps

module voxel_ray_traversal_dda_test;
    import vrt_pkg::*;

    localparam int STALL_LIMIT = 4000;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [143:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         psel = 0;
    logic         penable = 0;
    logic         pwrite = 0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    int           fail_count;
    int           pending;
    int           idle_cycles = 0;
    int           rays = 0;
    int           steps = 0;

    always #6 aclk = ~aclk;

    voxel_ray_traversal_dda uut (.*);

    voxel_ray_traversal_dda_check check (.*);

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int w;
        forever begin
            @(negedge aclk);
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (w > 0) begin
                m_tready <= 1'b0;
                repeat (w) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic write_size(logic [1:0] idx, logic [31:0] v);
        @(negedge aclk);
        psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= v;
        @(negedge aclk);
        penable <= 1;
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic send_item(logic req, logic [143:0] d, bit gaps);
        int w;
        w = gaps ? $urandom_range(0, 14) : 0;
        if (w > 0) begin
            s_tvalid <= 1'b0;
            repeat (w) @(negedge aclk);
        end
        s_tvalid <= 1'b1; s_tuser <= req; s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (req) steps++; else rays++;
    endtask

    function automatic logic [15:0] rand_heading();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'h8000;
            2: return 16'h7fff;
            3: return 16'hffff;
            4: return 16'h0001;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [143:0] rand_ray();
        logic [143:0] d;
        for (int a = 0; a < 3; a++) begin
            d[32*a +: 32] = ($urandom_range(0, 5) == 0) ? 32'hffffffff : $urandom();
            d[96 + 16*a +: 16] = rand_heading();
        end
        return d;
    endfunction

    task automatic settle();
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (600) @(negedge aclk);
    endtask

    initial begin
        logic [31:0] sizes [4];
        sizes = '{32'h10000, 32'h0, 32'hffffffff, 32'h1};
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        // Directed: advances before any start, extreme origins and headings.
        send_item(1'b1, '0, 1'b0);
        send_item(1'b1, '0, 1'b0);
        send_item(1'b0, '0, 1'b0);
        send_item(1'b1, '0, 1'b0);
        send_item(1'b0, {16'h8000, 16'h7fff, 16'h0001, {3{32'hffffffff}}}, 1'b0);
        repeat (4) send_item(1'b1, '0, 1'b0);
        send_item(1'b0, {16'h0000, 16'h0000, 16'h8000, 32'h0, 32'h0, 32'h0}, 1'b0);
        repeat (3) send_item(1'b1, '0, 1'b0);
        send_item(1'b0, {16'h0000, 16'h7fff, 16'h7fff, 32'h18000, 32'h8000, 32'h0}, 1'b0);
        repeat (4) send_item(1'b1, '0, 1'b0);
        for (int p = 0; p < 8; p++) begin
            settle();
            for (int a = 0; a < 3; a++) begin
                write_size(2'(a),
                           (p < 4) ? sizes[(p + a) % 4] : ($urandom() >> $urandom_range(0, 31)));
            end
            for (int r = 0; r < 11; r++) begin
                send_item(1'b0, rand_ray(), 1'b1);
                repeat ($urandom_range(2, 12))
                    send_item(1'b1, 144'($urandom()), $urandom_range(0, 1) == 1);
            end
        end
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (50) @(negedge aclk);
        $display("Covered %0d ray starts and %0d advances over eight cell size settings.",
                  rays, steps);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
